/* hw/rtl/smbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smbs_pkg: shared types and constants of the spi master byte shifter
// opcodes, configuration register indexes and the item/result records
// ----------------------------------------------------------------------------
package smbs_pkg;

    localparam int BYTE_W     = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_READ_RX = 2'd2,
        OP_STATUS  = 2'd3
    } t_opcode;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DIVISOR   = 2'd0,
        CFG_MODE      = 2'd1,
        CFG_MSB_FIRST = 2'd2
    } t_cfg_index;

    typedef struct packed {
        t_opcode           opcode;
        logic [BYTE_W-1:0] tx_byte;
        logic              miso_bit;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              sclk_level;
        logic              mosi_level;
        logic              tx_ready;
        logic              write_dropped;
    } t_result;

endpackage

/* hw/rtl/smbs_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smbs_in_stage: input register
// holds one accepted transaction until the engine takes it
// ----------------------------------------------------------------------------
module smbs_in_stage
    import smbs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* hw/rtl/smbs_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smbs_engine: divider, sclk generator and shift registers
// updates the transfer state for one transaction per i_fire cycle
// ----------------------------------------------------------------------------
module smbs_engine
    import smbs_pkg::*;
#(
    parameter int DATA_BITS = 8,
    parameter int DIV_BITS  = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  t_item               i_item,
    input  logic [DIV_BITS-1:0] i_divisor,
    input  logic [1:0]          i_mode,
    input  logic                i_msb_first,
    output t_result             o_result
);

    localparam int ECW = $clog2(2 * DATA_BITS + 1);
    localparam logic [ECW-1:0] LAST_EDGE = ECW'(2 * DATA_BITS);

    logic [DATA_BITS-1:0] r_tx_shift, n_tx_shift;
    logic [DATA_BITS-1:0] r_rx_shift, n_rx_shift;
    logic [DATA_BITS-1:0] r_rx_hold,  n_rx_hold;
    logic [ECW-1:0]       r_edge_count, n_edge_count;
    logic [DIV_BITS-1:0]  r_tick_count, n_tick_count;
    logic                 r_clock_level, n_clock_level;
    logic                 r_busy, n_busy;

    logic [DATA_BITS+BYTE_W-1:0] word_ext;
    logic [DATA_BITS+BYTE_W-1:0] hold_ext;
    logic [DATA_BITS-1:0]        word;
    logic [ECW-1:0]              edge_next;
    logic                        cpha;
    logic                        cpol;
    logic                        do_sample;
    logic                        do_shift;
    logic [BYTE_W-1:0]           rd;
    logic                        dropped;

    assign cpha     = i_mode[0];
    assign cpol     = i_mode[1];
    assign word_ext = {{DATA_BITS{1'b0}}, i_item.tx_byte};
    assign word     = word_ext[DATA_BITS-1:0];
    assign hold_ext = {{BYTE_W{1'b0}}, r_rx_hold};
    assign edge_next = r_edge_count + ECW'(1);
    assign do_sample = edge_next[0] ^ cpha;
    assign do_shift  = cpha ? (edge_next > ECW'(1)) : (edge_next < LAST_EDGE);

    always_comb begin
        case (i_item.opcode)
            OP_READ_RX: rd = hold_ext[BYTE_W-1:0];
            OP_STATUS:  rd = {{(BYTE_W-1){1'b0}}, !r_busy};
            default:    rd = '0;
        endcase
    end

    // next state of the transfer
    always_comb begin
        n_tx_shift    = r_tx_shift;
        n_rx_shift    = r_rx_shift;
        n_rx_hold     = r_rx_hold;
        n_edge_count  = r_edge_count;
        n_tick_count  = r_tick_count;
        n_clock_level = r_clock_level;
        n_busy        = r_busy;
        dropped       = 1'b0;
        if (i_item.opcode == OP_WRITE && !r_busy) begin
            n_tx_shift    = word;
            n_rx_shift    = '0;
            n_edge_count  = '0;
            n_tick_count  = '0;
            n_clock_level = cpol;
            n_busy        = 1'b1;
        end else begin
            dropped = (i_item.opcode == OP_WRITE);
            if (r_busy) begin
                if (r_tick_count < i_divisor) begin
                    n_tick_count = r_tick_count + DIV_BITS'(1);
                end else begin
                    n_tick_count  = '0;
                    n_clock_level = !r_clock_level;
                    n_edge_count  = edge_next;
                    if (do_sample) begin
                        n_rx_shift = i_msb_first
                            ? {r_rx_shift[DATA_BITS-2:0], i_item.miso_bit}
                            : {i_item.miso_bit, r_rx_shift[DATA_BITS-1:1]};
                    end else if (do_shift) begin
                        n_tx_shift = i_msb_first
                            ? {r_tx_shift[DATA_BITS-2:0], 1'b0}
                            : {1'b0, r_tx_shift[DATA_BITS-1:1]};
                    end
                    if (edge_next >= LAST_EDGE) begin
                        n_rx_hold    = n_rx_shift;
                        n_busy       = 1'b0;
                        n_edge_count = '0;
                    end
                end
            end
        end
    end

    always_comb begin
        o_result.read_data     = rd;
        o_result.sclk_level    = n_busy ? n_clock_level : cpol;
        o_result.mosi_level    = n_busy &&
            (i_msb_first ? n_tx_shift[DATA_BITS-1] : n_tx_shift[0]);
        o_result.tx_ready      = !n_busy;
        o_result.write_dropped = dropped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_shift    <= '0;
            r_rx_shift    <= '0;
            r_rx_hold     <= '0;
            r_edge_count  <= '0;
            r_tick_count  <= '0;
            r_clock_level <= 1'b0;
            r_busy        <= 1'b0;
        end else if (i_fire) begin
            r_tx_shift    <= n_tx_shift;
            r_rx_shift    <= n_rx_shift;
            r_rx_hold     <= n_rx_hold;
            r_edge_count  <= n_edge_count;
            r_tick_count  <= n_tick_count;
            r_clock_level <= n_clock_level;
            r_busy        <= n_busy;
        end
    end

endmodule

/* hw/rtl/spi_master_byte_shifter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_master_byte_shifter_core: programmable spi master, one item per unstalled clock
// each input transaction is a tick or a bus access; one result per input
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one item per transaction: tuser holds the opcode (tick,
//   write tx, read rx, read status), tdata the tx byte and the miso level.
//   m_axis returns one result per item: read data, sclk and mosi levels,
//   tx ready and a dropped-write flag.
//   the user keeps config port (divisor, mode, bit order) writes to idle; not enforced.
// path: the input register loads the item at the accepting edge, and the
//   engine result is registered in the output register when the item fires.
// throughput: one item per cycle while m_axis takes results, set by
//   the state update in the engine between the input and output registers.
// reset: synchronous, active low; clears the transfer state, divisor 0,
//   mode 0, msb first.
// stall: while m_axis is not taken the output register holds, the input
//   register fills and s_axis_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module spi_master_byte_shifter_core
    import smbs_pkg::*;
#(
    parameter int DATA_BITS = 8,
    parameter int DIV_BITS  = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // tx_byte[7:0], miso_bit[8]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,  // opcode[1:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // read_data[7:0], sclk_level[8], mosi_level[9], tx_ready[10],
    // write_dropped[11]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [DIV_BITS-1:0]   i_cfg_wdata
);

    logic [DIV_BITS-1:0] r_divisor;
    logic [1:0]          r_mode;
    logic                r_msb_first;
    logic                r_out_valid;
    t_result             r_result;

    t_item   in_item;
    t_item   st_item;
    t_result eng_result;
    logic    st_valid;
    logic    out_free;
    logic    fire;

    assign in_item.opcode   = t_opcode'(s_axis_tuser);
    assign in_item.tx_byte  = s_axis_tdata[BYTE_W-1:0];
    assign in_item.miso_bit = s_axis_tdata[BYTE_W];

    assign out_free = !r_out_valid || m_axis_tready;
    assign fire     = st_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor   <= '0;
            r_mode      <= '0;
            r_msb_first <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_addr))
                CFG_DIVISOR:   r_divisor   <= i_cfg_wdata;
                CFG_MODE:      r_mode      <= i_cfg_wdata[1:0];
                CFG_MSB_FIRST: r_msb_first <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    smbs_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (st_valid),
        .o_item  (st_item),
        .i_take  (fire)
    );

    smbs_engine #(
        .DATA_BITS (DATA_BITS),
        .DIV_BITS  (DIV_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (st_item),
        .i_divisor   (r_divisor),
        .i_mode      (r_mode),
        .i_msb_first (r_msb_first),
        .o_result    (eng_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= eng_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_result.write_dropped, r_result.tx_ready,
                            r_result.mosi_level, r_result.sclk_level,
                            r_result.read_data};

    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled with an empty output register");

    a_mosi_low_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.tx_ready) |-> !r_result.mosi_level)
        else $error("mosi driven while idle");

    a_fire_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("engine result not registered");

endmodule
